@@ rtl/core/wsr_pkg.sv @@
// ----------------------------------------------------------------------------
// wsr_pkg
// Shared types and constants for the wavetable spline resampler.
// ----------------------------------------------------------------------------
package wsr_pkg;

  localparam int SampleDepth = 65536;
  localparam int AddrW       = $clog2(SampleDepth);
  localparam int BankW       = AddrW - 2;
  localparam int CountW      = 17;
  localparam int QueueDepth  = 4;
  localparam int QPtrW       = 2;

  localparam logic [0:0] RegSampleCount = 1'b0;

  // Item after classification, queued from front to back in order.
  typedef struct packed {
    logic        ld;          // load: idx is the table address, ldata the value
    logic        done;        // index at or beyond sample count
    logic [16:0] idx;         // rounded sample index (low part used when not done)
    logic [16:0] frac;        // signed Q0.16 fraction
    logic [16:0] cnt;         // sample count snapshot
    logic [15:0] ldata;       // load value
  } render_t;

endpackage

@@ rtl/core/wsr_front.sv @@
// ----------------------------------------------------------------------------
// wsr_front
// Accepts items, classifies renders and passes loads on in order.
// Pipeline: registered multiply, then combinational rounding/classification into queue.
// ----------------------------------------------------------------------------
module wsr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  mode,
  input  logic [15:0]           load_index,
  input  logic signed [15:0]    load_value,
  input  logic [31:0]           elapsed_ticks,
  input  logic [23:0]           step_ratio,
  input  logic [16:0]           sample_count,
  output logic                  r_valid,
  output wsr_pkg::render_t      r_item,
  input  logic                  r_ready
);
  import wsr_pkg::*;

  logic        s1_valid;
  logic [55:0] s1_pos;
  logic [16:0] s1_cnt;
  logic        s1_ld;
  logic [15:0] s1_laddr;
  logic [15:0] s1_ldata;
  logic [39:0] rnd;
  logic        s1_adv;

  assign s1_adv   = !s1_valid || r_ready;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_pos   <= 56'(elapsed_ticks) * 56'(step_ratio);
      s1_cnt   <= sample_count;
      s1_ld    <= !mode;
      s1_laddr <= load_index;
      s1_ldata <= load_value;
    end
  end

  assign rnd = 40'((57'(s1_pos) + 57'h8000) >> 16);

  always_comb begin
    r_valid      = s1_valid;
    r_item.ld    = s1_ld;
    r_item.done  = (rnd >= 40'(s1_cnt));
    r_item.idx   = s1_ld ? {1'b0, s1_laddr} : rnd[16:0];
    r_item.frac  = 17'(s1_pos[16:0]) - {rnd[0], 16'h0};
    r_item.cnt   = s1_cnt;
    r_item.ldata = s1_ldata;
  end
endmodule

@@ rtl/core/wsr_queue.sv @@
// ----------------------------------------------------------------------------
// wsr_queue
// Short FIFO between front and back halves.
// ----------------------------------------------------------------------------
module wsr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  wsr_pkg::render_t wr_item,
  output logic             rd_valid,
  input  logic             rd_ready,
  output wsr_pkg::render_t rd_item
);
  import wsr_pkg::*;

  render_t           mem [QueueDepth];
  logic [QPtrW-1:0]  wp, rp;
  logic [QPtrW:0]    fill;
  logic              wr, rd;

  assign wr_ready = (fill != 3'(QueueDepth));
  assign rd_valid = (fill != '0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      fill <= fill + 3'(wr) - 3'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_item;
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 3'(QueueDepth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (fill == 0) |-> !rd_valid)
    else $error("read from empty");
  assert property (@(posedge clk) disable iff (rst) (wr && !rd) |=> fill == $past(fill) + 1)
    else $error("fill count slip");
endmodule

@@ rtl/core/wsr_back.sv @@
// ----------------------------------------------------------------------------
// wsr_back
// Banked table with in-order loads, and pipelined Horner evaluation.
// ----------------------------------------------------------------------------
module wsr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  wsr_pkg::render_t q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic signed [15:0] sample_out,
  output logic             finished
);
  import wsr_pkg::*;

  localparam int NS = 8;

  // Pipeline stages: 0 read/load write, 1 coefs, 2..6 Horner steps, 7 sum/sat out.
  logic        v   [NS];
  logic        adv;
  assign adv = !v[NS-1] || out_ready;
  assign q_ready = adv;

  // four banks, index mod 4
  logic signed [15:0] bank0 [SampleDepth/4];
  logic signed [15:0] bank1 [SampleDepth/4];
  logic signed [15:0] bank2 [SampleDepth/4];
  logic signed [15:0] bank3 [SampleDepth/4];
  logic [BankW-1:0]   ba [4];
  logic signed [15:0] rd [4];
  logic [17:0]        nb [4];
  logic               inr [4];
  logic [1:0]         rot;
  logic               tbl_we;
  logic [BankW-1:0]   tbl_wa;

  // loads write when they leave the queue, so earlier renders read old data
  assign tbl_we = adv && q_valid && q_item.ld;
  assign tbl_wa = q_item.idx[AddrW-1:2];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      nb[k]  = 18'(q_item.idx) + 18'(k) - 18'd1;
      inr[k] = !nb[k][17] && (nb[k][16:0] < q_item.cnt) && (nb[k] < 18'(SampleDepth));
    end
    for (int b = 0; b < 4; b++) begin
      ba[b] = '0;
      for (int k = 0; k < 4; k++)
        if (nb[k][1:0] == 2'(b)) ba[b] = nb[k][AddrW-1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we && q_item.idx[1:0] == 2'd0) bank0[tbl_wa] <= q_item.ldata;
    if (tbl_we && q_item.idx[1:0] == 2'd1) bank1[tbl_wa] <= q_item.ldata;
    if (tbl_we && q_item.idx[1:0] == 2'd2) bank2[tbl_wa] <= q_item.ldata;
    if (tbl_we && q_item.idx[1:0] == 2'd3) bank3[tbl_wa] <= q_item.ldata;
    if (adv) begin
      rd[0] <= bank0[ba[0]];
      rd[1] <= bank1[ba[1]];
      rd[2] <= bank2[ba[2]];
      rd[3] <= bank3[ba[3]];
    end
  end

  logic               s0_done;
  logic signed [16:0] s0_x;
  logic [3:0]         s0_in;
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_done <= q_item.done;
      s0_x    <= q_item.frac;
      rot     <= nb[0][1:0];
      for (int k = 0; k < 4; k++) s0_in[k] <= inr[k];
    end
  end

  logic signed [15:0] nbr [4];
  always_comb
    for (int k = 0; k < 4; k++)
      nbr[k] = s0_in[k] ? rd[2'(rot + 2'(k))] : 16'sd0;

  // per-stage payload
  logic               done [NS];
  logic signed [16:0] x    [NS];
  logic signed [15:0] l0   [NS];
  logic signed [23:0] c1 [NS], c2 [NS], c3 [NS], c4 [NS];
  logic signed [23:0] acc  [NS];

  function automatic logic signed [23:0] rs(input logic signed [47:0] p, input int sh);
    logic signed [47:0] t;
    t = (p + (48'sd1 <<< sh)) >>> (sh + 1);
    return 24'(t);
  endfunction

  // stage 1: coefficients
  logic signed [19:0] a, b;
  assign a = 20'(nbr[2]) - 20'(nbr[1]);   // H0-L0
  assign b = 20'(nbr[0]) - 20'(nbr[3]);   // L1-H1
  always_ff @(posedge clk) begin
    if (adv) begin
      done[1] <= s0_done; x[1] <= s0_x; l0[1] <= nbr[1];
      c1[1] <= 24'(nbr[2]) - 24'(nbr[0]);
      c2[1] <= 24'(24'(nbr[2]) - 24'(nbr[1]) * 2 + 24'(nbr[0]));
      c3[1] <= 24'(24'(a) * 9 + 24'(b) * 3);
      c4[1] <= 24'(-(24'(a) * 15) - 24'(b) * 5);
      acc[1] <= 24'(24'(a) * 6 + 24'(b) * 2);
    end
  end

  // stages 2..5: Horner steps with c4, c3, c2, c1; stage 6: final x/2 term
  for (genvar g = 2; g <= 6; g++) begin : g_h
    logic signed [47:0] p;
    logic signed [23:0] ck;
    assign p = 48'(acc[g-1]) * 48'(x[g-1]);
    always_comb begin
      unique case (g)
        2: ck = c4[g-1];
        3: ck = c3[g-1];
        4: ck = c2[g-1];
        5: ck = c1[g-1];
        default: ck = '0;
      endcase
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        done[g] <= done[g-1]; x[g] <= x[g-1]; l0[g] <= l0[g-1];
        c1[g] <= c1[g-1]; c2[g] <= c2[g-1]; c3[g] <= c3[g-1]; c4[g] <= c4[g-1];
        acc[g] <= (g == 6) ? rs(p, 16) : ck + rs(p, 15);
      end
    end
  end

  logic signed [24:0] ysum;
  assign ysum = 25'(l0[6]) + 25'(acc[6]);
  always_ff @(posedge clk) begin
    if (adv) begin
      finished <= done[6];
      if (done[6]) sample_out <= '0;
      else if (ysum > 25'sd32767) sample_out <= 16'sh7fff;
      else if (ysum < -25'sd32768) sample_out <= 16'sh8000;
      else sample_out <= 16'(ysum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) v[s] <= 1'b0;
    end else if (adv) begin
      v[0] <= q_valid && !q_item.ld;
      for (int s = 1; s < NS; s++) v[s] <= v[s-1];
    end
  end
  assign out_valid = v[NS-1];

  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) out_valid && finished |-> sample_out == 0)
    else $error("finished with nonzero sample");
  assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(sample_out))
    else $error("result changed while stalled");
endmodule

@@ rtl/core/wavetable_spline_resampler.sv @@
// ----------------------------------------------------------------------------
// wavetable_spline_resampler
// Wavetable playback with 4-point 5th-order spline interpolation.
// ----------------------------------------------------------------------------
// Path: a render passes the front register, one queue slot and eight back
//   stages in order; it waits there only while the output stalls.
// Throughput: one item per cycle while the output does not stall; four
//   neighbors read per cycle from a table banked by index mod 4.
// Loads pass the queue in order, write the table as they leave the queue
//   and give no result.
// Reset clears control state and sample_count; table contents stay undefined.
module wavetable_spline_resampler (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [15:0]        load_index,
  input  logic signed [15:0] load_value,
  input  logic [31:0]        elapsed_ticks,
  input  logic [23:0]        step_ratio,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  output logic               finished
);
  import wsr_pkg::*;

  logic [CountW-1:0] sample_count;
  logic              f_valid, f_ready, b_valid, b_ready;
  render_t           f_item, b_item;

  // register file: one register at byte address 0 (paddr is the word bit)
  assign pready = 1'b1;
  assign prdata = (paddr == RegSampleCount) ? 32'(sample_count) : 32'h0;
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (psel && penable && pwrite && paddr == RegSampleCount) begin
      sample_count <= pwdata[CountW-1:0];
    end
  end

  wsr_front u_front (
    .clk, .rst, .in_valid, .in_ready, .mode, .load_index, .load_value,
    .elapsed_ticks, .step_ratio, .sample_count,
    .r_valid(f_valid), .r_item(f_item), .r_ready(f_ready)
  );

  wsr_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
  );

  wsr_back u_back (
    .clk, .rst,
    .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .out_valid, .out_ready, .sample_out, .finished
  );
endmodule
